[src/gcd_chunk_dim_split_macros.svh]
// Assertion helpers used by the checker file.
`ifndef GCD_CHUNK_DIM_SPLIT_MACROS_SVH
`define GCD_CHUNK_DIM_SPLIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, muted while rst_ni is low.
`define GCDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, muted while rst_ni is low.
`define GCDS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[src/gcds_pkg.sv]
`default_nettype none

package gcds_pkg;

  // Width of sizes, factors and the chunk register.
  localparam int unsigned DataW = 32;
  // Width of the shared-power-of-two counter and the divider bit counter.
  localparam int unsigned CntW  = $clog2(DataW);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the input beat, load gcd operands
    logic gcd_step;   // one binary gcd step
    logic div_ld_sz;  // start dividing the size by g
    logic div_step;   // one restoring division step
    logic div_ld_rem; // capture size quotient, start dividing the factor by g
    logic rem_wr;     // commit the new remaining factor
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need;       // input beat needs the gcd split
    logic gcd_done;   // gcd operand a reached zero
    logic div_last;   // divider is on its final bit
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

[src/gcds_ctrl.sv]
`default_nettype none

module gcds_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gcds_pkg::sts_t sts_i,
  output gcds_pkg::cmd_t cmd_o
);
  import gcds_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_GCD     = 6'b000010,
    S_DIV_SZ  = 6'b000100,
    S_LD_REM  = 6'b001000,
    S_DIV_REM = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e state_d, state_q;

  assign in_ready_o = (state_q == S_IDLE);

  // Item: gcd, size and factor division, result; or result alone.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.need ? S_GCD : S_DONE;
        end
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_ld_sz = 1'b1;
          state_d         = S_DIV_SZ;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIV_SZ: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_LD_REM;
      end
      S_LD_REM: begin
        cmd_o.div_ld_rem = 1'b1;
        state_d          = S_DIV_REM;
      end
      S_DIV_REM: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.rem_wr = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/gcds_dpath.sv]
`default_nettype none

module gcds_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gcds_pkg::cmd_t             cmd_i,
  output gcds_pkg::sts_t             sts_o,
  input  logic                       cfg_we_i,
  input  logic [gcds_pkg::DataW-1:0] cfg_wdata_i,
  input  logic [gcds_pkg::DataW-1:0] dim_size_i,
  input  logic                       is_dynamic_i,
  input  logic                       last_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [gcds_pkg::DataW-1:0] new_size_o,
  output logic                       last_res_o,
  output logic                       ok_o
);
  import gcds_pkg::*;

  logic [DataW-1:0] chunk_q, rem_q, rem_d;
  logic             run_start_q;
  logic [DataW-1:0] size_q, res_q;
  logic             last_q, calc_q;
  logic [DataW-1:0] a_q, b_q;
  logic [CntW-1:0]  k_q;
  logic [DataW-1:0] div_d_q, div_n_q, div_r_q;
  logic [CntW-1:0]  cnt_q;
  logic             out_valid_q;
  logic [DataW-1:0] new_size_q;
  logic             last_res_q, ok_q;

  logic [DataW-1:0] rem_eff;
  logic [DataW-1:0] g_val;
  logic [DataW:0]   div_t, div_diff;
  logic             div_ge;
  logic [DataW-1:0] rem_final;

  // Pick the factor for this beat: reload from the register at a run start.
  assign rem_eff = run_start_q ? chunk_q : rem_q;
  assign g_val   = b_q << k_q;

  // One restoring division step.
  assign div_t    = {div_r_q, div_n_q[DataW-1]};
  assign div_diff = div_t - {1'b0, div_d_q};
  assign div_ge   = (div_t >= {1'b0, div_d_q});

  assign rem_final = calc_q ? div_n_q : rem_q;
  assign rem_d     = cmd_i.accept ? rem_eff : (cmd_i.rem_wr ? rem_final : rem_q);

  assign sts_o.need     = !is_dynamic_i && (rem_eff > DataW'(1));
  assign sts_o.gcd_done = (a_q == '0);
  assign sts_o.div_last = (cnt_q == {CntW{1'b1}});
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Control state: chunk register, factor, run start, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q     <= DataW'(1);
      rem_q       <= DataW'(1);
      run_start_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) chunk_q <= cfg_wdata_i;
      rem_q <= rem_d;
      if (cmd_i.accept) run_start_q <= last_i;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the beat and run binary gcd.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      size_q <= dim_size_i;
      last_q <= last_i;
      calc_q <= sts_o.need;
      a_q    <= dim_size_i;
      b_q    <= rem_eff;
      k_q    <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + CntW'(1);
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q >= b_q) begin
        a_q <= a_q - b_q;
      end else begin
        b_q <= b_q - a_q;
      end
    end
  end

  // Shared divider: size / g, then factor / g.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_ld_sz) begin
      div_d_q <= g_val;
      div_n_q <= size_q;
      div_r_q <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.div_ld_rem) begin
      div_n_q <= rem_q;
      div_r_q <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.div_step) begin
      div_r_q <= div_ge ? div_diff[DataW-1:0] : div_t[DataW-1:0];
      div_n_q <= {div_n_q[DataW-2:0], div_ge};
      cnt_q   <= cnt_q + CntW'(1);
    end
  end

  // Hold the result size: pass through, or take the size quotient.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_q <= dim_size_i;
    end else if (cmd_i.div_ld_rem) begin
      res_q <= div_n_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      new_size_q <= res_q;
      last_res_q <= last_q;
      ok_q       <= last_q && (rem_final <= DataW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_size_o  = new_size_q;
  assign last_res_o  = last_res_q;
  assign ok_o        = ok_q;

endmodule

`default_nettype wire

[src/gcd_chunk_dim_split.sv]
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   dim_size_i, is_dynamic_i, last_i
// out      out_valid_o / out_ready_i new_size_o, last_res_o, ok_o
// cfg      cfg_we_i                  cfg_wdata_i (chunk count)
//
// One item at a time. A dynamic item, or one arriving once the factor is down
// to 1, skips the split and goes straight to the result. Any other item first
// runs binary gcd steps, then two passes of the shared bit-serial divider.
// The output register lets a new item start while a result waits; a finished
// item stalls until that register is free. Reset: chunk count 1, new run.
`default_nettype none

module gcd_chunk_dim_split (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gcds_pkg::DataW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [gcds_pkg::DataW-1:0] dim_size_i,
  input  logic                       is_dynamic_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gcds_pkg::DataW-1:0] new_size_o,
  output logic                       last_res_o,
  output logic                       ok_o
);
  import gcds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gcds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gcds_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .dim_size_i   (dim_size_i),
    .is_dynamic_i (is_dynamic_i),
    .last_i       (last_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .new_size_o   (new_size_o),
    .last_res_o   (last_res_o),
    .ok_o         (ok_o)
  );

endmodule

`default_nettype wire

[src/gcds_checker.sv]
`default_nettype none
`include "gcd_chunk_dim_split_macros.svh"

module gcds_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic last_res_o,
  input logic ok_o
);

  // Success is only ever flagged on the final beat of a run.
  `GCDS_ASSERT(a_ok_on_last, out_valid_o && ok_o |-> last_res_o, "ok without last")

  // One item in flight: an accepted input drops ready for the next cycle.
  `GCDS_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")

  // A new result is produced exactly as the block returns to idle.
  `GCDS_ASSERT(a_rise_idle, $rose(out_valid_o) |-> in_ready_o, "result without idle")

  // Hold a stalled result beat.
  `GCDS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output dropped")

endmodule

bind gcd_chunk_dim_split gcds_checker u_gcds_checker (.*);

`default_nettype wire
